>>> rtl/iba_pkg.sv
// ============================================================================
// iba_pkg: shared types and constants of the interleaved block allocator
// Request codes, register indexes, and the command and status groups that
// pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package iba_pkg;

    localparam int NUM_BLOCKS_DEF = 578;

    localparam int REQ_W   = 2;
    localparam int OWNER_W = 5;
    localparam int INDEX_W = 10;
    localparam int BLOCK_W = 10;
    localparam int SPACE_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [SPACE_W-1:0] SPACING_RST = 4'd4;
    localparam logic [INDEX_W-1:0] START_RST   = 10'd99;

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } iba_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACING = 2'd0,
        CFG_START   = 2'd1,
        CFG_UPWARD  = 2'd2,
        CFG_SPARE   = 2'd3
    } iba_cfg_t;

    typedef struct packed {
        logic load_req;
        logic clr_wr;
        logic begin_file;
        logic scan_read;
        logic take_block;
        logic step;
        logic bounce;
        logic fail;
        logic entry_write;
        logic entry_read;
        logic read_capture;
        logic out_load;
    } iba_cmd_t;

    typedef struct packed {
        logic     clr_done;
        iba_req_t req_type;
        logic     in_range;
        logic     entry_free;
        logic     out_free;
    } iba_stat_t;

endpackage

`default_nettype wire

>>> rtl/iba_ram.sv
// ============================================================================
// iba_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module iba_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 578
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/iba_ctrl.sv
// ============================================================================
// iba_ctrl: request sequencer
// Clears the table after reset, decodes requests, runs the scan passes and
// hands each result to the output register.
// ============================================================================
`default_nettype none

module iba_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire iba_pkg::iba_stat_t  stat,
    output iba_pkg::iba_cmd_t        cmd
);

    import iba_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_READ_WAIT,
        ST_RESP
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] pass_reg, pass_next;

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                pass_next = 2'd0;
                case (stat.req_type)
                    REQ_BEGIN: begin
                        cmd.begin_file = 1'b1;
                        state_next     = ST_RESP;
                    end
                    REQ_ALLOC: begin
                        state_next = ST_SCAN_RD;
                    end
                    REQ_WRITE: begin
                        cmd.entry_write = 1'b1;
                        state_next      = ST_RESP;
                    end
                    REQ_READ: begin
                        cmd.entry_read = 1'b1;
                        state_next     = ST_READ_WAIT;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SCAN_RD: begin
                if (stat.in_range) begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_SCAN_CHK;
                end else begin
                    cmd.bounce = 1'b1;
                    if (pass_reg == 2'd2) begin
                        cmd.fail   = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        pass_next = pass_reg + 2'd1;
                    end
                end
            end
            ST_SCAN_CHK: begin
                if (stat.entry_free) begin
                    cmd.take_block = 1'b1;
                    state_next     = ST_RESP;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_READ_WAIT: begin
                cmd.read_capture = 1'b1;
                state_next       = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pass_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/iba_datapath.sv
// ============================================================================
// iba_datapath: owner table, scan pointer and result registers
// Holds the configuration, the request, the pointer and direction, the
// owner RAM with its clearing counter, and the output register.
// ============================================================================
`default_nettype none

module iba_datapath #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [iba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [iba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [iba_pkg::REQ_W-1:0]       s_req_type,
    input  wire logic [iba_pkg::OWNER_W-1:0]     s_owner,
    input  wire logic [iba_pkg::INDEX_W-1:0]     s_entry_index,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [iba_pkg::BLOCK_W-1:0]     m_block_number,
    output logic                                 m_status,
    output logic      [iba_pkg::OWNER_W-1:0]     m_owner_read,
    input  wire iba_pkg::iba_cmd_t               cmd,
    output iba_pkg::iba_stat_t                   stat
);

    import iba_pkg::*;

    localparam int AW      = $clog2(NUM_BLOCKS);
    localparam int PTR_MAX = (NUM_BLOCKS + 16 > 1023) ? NUM_BLOCKS + 16 : 1023;
    localparam int PTR_W   = $clog2(PTR_MAX + 3) + 1;

    localparam logic signed [PTR_W-1:0] PTR_NUM = PTR_W'(NUM_BLOCKS);
    localparam logic signed [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic signed [PTR_W-1:0] PTR_TWO = PTR_W'(2);

    logic [SPACE_W-1:0]  spacing_reg;
    logic [INDEX_W-1:0]  start_reg;
    logic                upward_reg;

    iba_req_t            req_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic [INDEX_W-1:0]  idx_reg;

    logic signed [PTR_W-1:0] ptr_reg, ptr_next;
    logic                    down_reg, down_next;

    logic [AW-1:0]       clr_cnt_reg;

    logic [BLOCK_W-1:0]  blk_res_reg;
    logic                stat_res_reg;
    logic [OWNER_W-1:0]  rd_res_reg;

    logic                m_valid_reg;
    logic [BLOCK_W-1:0]  m_block_number_reg;
    logic                m_status_reg;
    logic [OWNER_W-1:0]  m_owner_read_reg;

    logic                idx_ok;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [OWNER_W-1:0]  ram_wdata, ram_rdata;
    logic signed [PTR_W-1:0] spacing_ext;

    assign idx_ok      = {1'b0, idx_reg} < (INDEX_W + 1)'(NUM_BLOCKS);
    assign spacing_ext = signed'({{(PTR_W - SPACE_W){1'b0}}, spacing_reg});

    // owner RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = owner_reg;
        if (cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.take_block) begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg[AW-1:0];
        end else if (cmd.entry_write) begin
            ram_we    = idx_ok;
        end
        ram_re    = cmd.scan_read | (cmd.entry_read & idx_ok);
        ram_raddr = cmd.scan_read ? ptr_reg[AW-1:0] : idx_reg[AW-1:0];
    end

    iba_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pointer and direction
    always_comb begin
        ptr_next  = ptr_reg;
        down_next = down_reg;
        if (cmd.begin_file) begin
            ptr_next  = signed'({{(PTR_W - INDEX_W){1'b0}}, start_reg});
            down_next = ~upward_reg;
        end else if (cmd.take_block) begin
            ptr_next = down_reg ? ptr_reg - spacing_ext : ptr_reg + spacing_ext;
        end else if (cmd.step) begin
            ptr_next = down_reg ? ptr_reg - PTR_ONE : ptr_reg + PTR_ONE;
        end else if (cmd.bounce) begin
            down_next = ~down_reg;
            ptr_next  = down_reg ? ptr_reg + PTR_TWO : ptr_reg - PTR_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= SPACING_RST;
            start_reg   <= START_RST;
            upward_reg  <= 1'b0;
            ptr_reg     <= signed'({{(PTR_W - INDEX_W){1'b0}}, START_RST});
            down_reg    <= 1'b1;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SPACING: spacing_reg <= cfg_data[SPACE_W-1:0];
                    CFG_START:   start_reg   <= cfg_data[INDEX_W-1:0];
                    CFG_UPWARD:  upward_reg  <= cfg_data[0];
                    default:     ;
                endcase
            end
            ptr_reg  <= ptr_next;
            down_reg <= down_next;
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg      <= iba_req_t'(s_req_type);
            owner_reg    <= s_owner;
            idx_reg      <= s_entry_index;
            blk_res_reg  <= '0;
            stat_res_reg <= 1'b0;
            rd_res_reg   <= '0;
        end
        if (cmd.take_block) begin
            blk_res_reg <= ptr_reg[BLOCK_W-1:0];
        end
        if (cmd.fail) begin
            stat_res_reg <= 1'b1;
        end
        if (cmd.read_capture) begin
            rd_res_reg <= idx_ok ? ram_rdata : '0;
        end
        if (cmd.out_load) begin
            m_block_number_reg <= blk_res_reg;
            m_status_reg       <= stat_res_reg;
            m_owner_read_reg   <= rd_res_reg;
        end
    end

    assign stat.clr_done   = (clr_cnt_reg == AW'(NUM_BLOCKS - 1));
    assign stat.req_type   = req_reg;
    assign stat.in_range   = (ptr_reg > 0) && (ptr_reg < PTR_NUM);
    assign stat.entry_free = (ram_rdata == '0);
    assign stat.out_free   = ~m_valid_reg | m_ready;

    assign m_valid        = m_valid_reg;
    assign m_block_number = m_block_number_reg;
    assign m_status       = m_status_reg;
    assign m_owner_read   = m_owner_read_reg;

endmodule

`default_nettype wire

>>> rtl/interleaved_block_allocator.sv
// ============================================================================
// interleaved_block_allocator: interleaved free-block allocator
// Keeps a table of block owners and a bouncing scan pointer; serves
// begin-file, allocate, write-entry and read-entry requests.
// ============================================================================
//
// channel   direction  transfer carries
// s_        in         req_type, owner, entry_index
// m_        out        block_number, status, owner_read
// cfg_      in         register index, write data
//
// Begin-file and write requests go from decode straight to the result; reads
// first wait for the registered RAM data. An allocation examines entries
// (one RAM read and one check each) and makes at most 3 range bounces.
// After reset a clearing pass zeroes the table; s_ready stays low meanwhile,
// cfg writes are taken throughout.
// One request at a time; the next transfer is taken while the result waits.
//
`default_nettype none

module interleaved_block_allocator #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [iba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [iba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [iba_pkg::REQ_W-1:0]       s_req_type,
    input  wire logic [iba_pkg::OWNER_W-1:0]     s_owner,
    input  wire logic [iba_pkg::INDEX_W-1:0]     s_entry_index,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [iba_pkg::BLOCK_W-1:0]     m_block_number,
    output logic                                 m_status,
    output logic      [iba_pkg::OWNER_W-1:0]     m_owner_read
);

    import iba_pkg::*;

    iba_cmd_t  cmd;
    iba_stat_t stat;

    assign cfg_ready = 1'b1;

    iba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    iba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_req_type     (s_req_type),
        .s_owner        (s_owner),
        .s_entry_index  (s_entry_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_number (m_block_number),
        .m_status       (m_status),
        .m_owner_read   (m_owner_read),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

`default_nettype wire
